[rtl/lkv_pkg.sv]
// Package for the LRU key-value cache: beat payload types, cell entry type
// and operation codes. No dependencies.
package lkv_pkg;

   localparam int CAP_W = 5;

   localparam logic ACT_GET = 1'b0;
   localparam logic ACT_PUT = 1'b1;

   typedef struct packed {
      logic               action;
      logic        [31:0] key;
      logic signed [31:0] value;
   } req_type;

   typedef struct packed {
      logic               hit;
      logic signed [31:0] read_value;
   } rsp_type;

   typedef struct packed {
      logic               valid;
      logic        [31:0] key;
      logic signed [31:0] value;
   } entry_type;

endpackage

[rtl/lkv_cell.sv]
// One storage cell of the recency-ordered chain: holds an entry, compares its key
// and takes its neighbor's entry on a shift. Depends on lkv_pkg.
module lkv_cell
   import lkv_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        clear,
   input  logic        cmp_en,
   input  logic [31:0] cmp_key,
   input  logic        shift,
   input  entry_type   prev_entry,
   output entry_type   entry,
   output logic        match
);

   logic        valid_ff;
   logic        valid_in;
   logic [31:0] key_ff;
   logic signed [31:0] value_ff;
   logic        match_ff;
   logic        match_in;

   assign valid_in = clear ? 1'b0 : (shift ? prev_entry.valid : valid_ff);
   assign match_in = cmp_en ? (valid_ff && (key_ff == cmp_key)) : match_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         match_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
         match_ff <= match_in;
      end
   end

   always_ff @(posedge clock) begin
      if (shift) begin
         key_ff   <= prev_entry.key;
         value_ff <= prev_entry.value;
      end
   end

   assign entry.valid = valid_ff;
   assign entry.key   = key_ff;
   assign entry.value = value_ff;
   assign match       = match_ff;

endmodule

[rtl/lru_key_value_cache.sv]
// LRU key-value cache top level: chain of lkv_cell entries ordered by recency,
// control sequencer and response register. Depends on lkv_pkg and lkv_cell.
//
// Usage:
//   req channel (valid/ready) carries get or put beats with key and value.
//   rsp channel (valid/ready) returns one beat per request: hit flag and,
//   for a get hit, the stored value (zero otherwise).
//   csr_we/csr_wdata write the capacity; every write empties the store.
//   A capacity of zero acts as one, above ENTRIES it saturates.
// Sequence:
//   A request is registered when accepted, compared against all cells in the
//   match state, and its response is registered in the write state, which
//   waits while a held response is not taken. One request is in flight at a
//   time; the next one is accepted at the edge that writes the response, so
//   requests take the compare-then-shift sequence through the chain in turn.
//   Cell 0 is the most recent entry; the least recent live entry sits at
//   position live_count-1 and is the one dropped on eviction.
// Reset: all cells empty, capacity min(16, ENTRIES), no response pending.
// Stall: a pending response holds in the output register; an idle cache still
//   accepts a new request, and its update waits until the held beat is taken.
module lru_key_value_cache
   import lkv_pkg::*;
#(
   parameter int ENTRIES = 16
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  req_type          req_data,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output rsp_type          rsp_data,
   input  logic             csr_we,
   input  logic [CAP_W-1:0] csr_wdata
);

   localparam int IDX_W     = $clog2(ENTRIES);
   localparam int CNT_W     = $clog2(ENTRIES + 1);
   localparam int CAP_RESET = (16 > ENTRIES) ? ENTRIES : 16;

   localparam logic [1:0] S_IDLE  = 2'd0;
   localparam logic [1:0] S_MATCH = 2'd1;
   localparam logic [1:0] S_WRITE = 2'd2;

   logic [1:0]       state_ff;
   logic [1:0]       state_in;
   req_type          req_ff;
   logic [CNT_W-1:0] live_ff;
   logic [CNT_W-1:0] live_in;
   logic [CNT_W-1:0] cap_ff;
   logic [CNT_W-1:0] cap_in;
   logic             rsp_valid_ff;
   rsp_type          rsp_data_ff;

   entry_type        cell_q [ENTRIES];
   logic [ENTRIES-1:0] match;
   logic [ENTRIES-1:0] shift;
   entry_type        head;

   logic             req_fire;
   logic             write_go;
   logic             any_hit;
   logic [IDX_W-1:0] hit_pos;
   logic signed [31:0] hit_value;
   logic             is_put;
   logic             full;
   logic             do_shift;
   logic [IDX_W-1:0] limit;

   assign write_go  = (state_ff == S_WRITE) && (!rsp_valid_ff || rsp_ready);
   assign req_ready = (state_ff == S_IDLE) || write_go;
   assign req_fire  = req_valid && req_ready;
   assign is_put    = (req_ff.action == ACT_PUT);
   assign full      = (live_ff >= cap_ff);

   always_comb begin
      any_hit   = 1'b0;
      hit_pos   = '0;
      hit_value = '0;
      for (int i = 0; i < ENTRIES; i++) begin
         if (match[i]) begin
            any_hit   = 1'b1;
            hit_pos   = hit_pos | IDX_W'(i);
            hit_value = hit_value | cell_q[i].value;
         end
      end
   end

   always_comb begin
      do_shift = write_go && (any_hit || is_put);
      if (any_hit) begin
         limit = hit_pos;
      end else if (full) begin
         limit = IDX_W'(live_ff - 1'b1);
      end else begin
         limit = live_ff[IDX_W-1:0];
      end
   end

   assign head.valid = 1'b1;
   assign head.key   = req_ff.key;
   assign head.value = is_put ? req_ff.value : hit_value;

   genvar g;
   generate
      for (g = 0; g < ENTRIES; g++) begin : g_cell
         entry_type prev_entry;
         if (g == 0) begin : g_head
            assign prev_entry = head;
         end else begin : g_link
            assign prev_entry = cell_q[g-1];
         end
         assign shift[g] = do_shift && (IDX_W'(g) <= limit);
         lkv_cell u_cell (
            .clock      (clock),
            .reset      (reset),
            .clear      (csr_we),
            .cmp_en     (state_ff == S_MATCH),
            .cmp_key    (req_ff.key),
            .shift      (shift[g]),
            .prev_entry (prev_entry),
            .entry      (cell_q[g]),
            .match      (match[g])
         );
      end
   endgenerate

   always_comb begin
      int c;
      c = int'(csr_wdata);
      if (c == 0) begin
         c = 1;
      end else if (c > ENTRIES) begin
         c = ENTRIES;
      end
      cap_in = csr_we ? CNT_W'(c) : cap_ff;
   end

   always_comb begin
      live_in = live_ff;
      if (csr_we) begin
         live_in = '0;
      end else if (write_go && is_put && !any_hit && !full) begin
         live_in = live_ff + 1'b1;
      end
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (req_fire) begin
               state_in = S_MATCH;
            end
         end
         S_MATCH: begin
            state_in = S_WRITE;
         end
         S_WRITE: begin
            if (write_go) begin
               state_in = req_fire ? S_MATCH : S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         live_ff      <= '0;
         cap_ff       <= CNT_W'(CAP_RESET);
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         live_ff  <= live_in;
         cap_ff   <= cap_in;
         if (write_go) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         req_ff <= req_data;
      end
      if (write_go) begin
         rsp_data_ff.hit        <= any_hit;
         rsp_data_ff.read_value <= (any_hit && !is_put) ? hit_value : '0;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

[rtl/lkv_checker.sv]
// Port-level checks for the LRU key-value cache, bound to the top level.
// Depends on lkv_pkg and lru_key_value_cache.
module lkv_checker
   import lkv_pkg::*;
(
   input logic    clock,
   input logic    reset,
   input logic    req_valid,
   input logic    req_ready,
   input logic    rsp_valid,
   input logic    rsp_ready,
   input rsp_type rsp_data
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("rsp beat dropped or changed while stalled");

   a_miss_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_data.hit |-> rsp_data.read_value == 0)
      else $error("miss beat carries a nonzero value");

   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("request accepted during compare cycle");

   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("rsp beat pending after reset");

endmodule

bind lru_key_value_cache lkv_checker u_lkv_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_ready (req_ready),
   .rsp_valid (rsp_valid),
   .rsp_ready (rsp_ready),
   .rsp_data  (rsp_data)
);
